>>> hdl/text_console_writer_core_defines.svh
// Assertion macros shared by the text console writer modules
`ifndef TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH
`ifndef SYNTH
`define TCW_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("text console writer check failed");
`define TCW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("text console writer check failed");
`else
`define TCW_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define TCW_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> hdl/tcw_pkg.sv
// Types, constants and codes of the text console writer
package tcw_pkg;

   localparam int COLUMNS  = 80;
   localparam int ROWS     = 25;
   localparam int TAB_STEP = 4;

   localparam int CELL_COUNT   = COLUMNS * ROWS;
   localparam int COPY_CELLS   = COLUMNS * (ROWS - 1);
   localparam int SCROLL_POS   = COLUMNS * (ROWS - 1);
   localparam int CELL_AW      = $clog2(CELL_COUNT);
   localparam int CNT_W        = $clog2(CELL_COUNT + 1);

   localparam int OP_W     = 2;
   localparam int CHAR_W   = 8;
   localparam int ADDR_W   = 11;
   localparam int CELL_W   = 16;
   localparam int CURSOR_W = 11;
   localparam int LINE_W   = 5;
   localparam int COLOR_W  = 4;
   localparam int CSR_IDX_W = 1;

   localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;

   localparam logic [CSR_IDX_W-1:0] CSR_FORE_COLOR = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BACK_COLOR = 1'd1;

   localparam logic [COLOR_W-1:0] FORE_RESET = 4'd15;
   localparam logic [COLOR_W-1:0] BACK_RESET = 4'd0;
   localparam logic [CELL_W-1:0]  BLANK_RESET = {BACK_RESET, FORE_RESET, 8'd0};

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [CHAR_W-1:0] char_code;
      logic [ADDR_W-1:0] cell_address;
   } tcw_req_type;

   typedef struct packed {
      logic [CELL_W-1:0]   cell_data;
      logic [CURSOR_W-1:0] cursor_pos;
      logic [LINE_W-1:0]   line_number;
      logic                overflow;
   } tcw_rsp_type;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_PUT,
      ACT_TAB,
      ACT_NEWLINE,
      ACT_READ,
      ACT_NOP,
      ACT_CLEAR_START,
      ACT_SCROLL_START,
      ACT_FILL,
      ACT_SCROLL
   } tcw_act_type;

   typedef struct packed {
      tcw_act_type act;
      logic        fill_reset;
   } tcw_cmd_type;

   typedef struct packed {
      logic fill_last;
      logic scroll_last;
      logic at_last_line;
   } tcw_sts_type;

endpackage

>>> hdl/tcw_datapath.sv
// Cell store, cursor and line registers, sweep counter and result payload
`include "text_console_writer_core_defines.svh"

module tcw_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  tcw_pkg::tcw_cmd_type          cmd,
   input  tcw_pkg::tcw_req_type          req_data,
   input  logic                          csr_write_enable,
   input  logic [tcw_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tcw_pkg::COLOR_W-1:0]   csr_write_data,
   output tcw_pkg::tcw_sts_type          sts,
   output tcw_pkg::tcw_rsp_type          rsp_data
);
   import tcw_pkg::*;

   logic [CELL_W-1:0]   mem [CELL_COUNT];
   logic [CELL_W-1:0]   q_ff;
   logic [CURSOR_W-1:0] cursor_ff, cursor_in;
   logic [LINE_W-1:0]   line_ff, line_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [COLOR_W-1:0]  fore_ff, back_ff;
   logic                ovf_ff, ovf_in;
   logic                rd_ff, rd_in;

   logic                mem_we, mem_re;
   logic [CELL_AW-1:0]  mem_wa, mem_ra;
   logic [CELL_W-1:0]   mem_wd;
   logic [CELL_W-1:0]   blank;
   logic [CURSOR_W:0]   tab_sum;
   logic                cursor_at_end;

   assign blank         = {back_ff, fore_ff, CHAR_W'(0)};
   assign tab_sum       = {1'b0, cursor_ff} + (CURSOR_W + 1)'(TAB_STEP);
   assign cursor_at_end = cursor_ff >= CURSOR_W'(CELL_COUNT);

   always_comb begin
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_wa    = '0;
      mem_ra    = '0;
      mem_wd    = blank;
      cursor_in = cursor_ff;
      line_in   = line_ff;
      cnt_in    = cnt_ff;
      ovf_in    = ovf_ff;
      rd_in     = rd_ff;
      unique case (cmd.act)
         ACT_PUT: begin
            mem_we = !cursor_at_end;
            mem_wa = CELL_AW'(cursor_ff);
            mem_wd = {back_ff, fore_ff, req_data.char_code};
            ovf_in = cursor_at_end;
            rd_in  = 1'b0;
            if (!cursor_at_end) begin
               cursor_in = cursor_ff + CURSOR_W'(1);
            end
         end
         ACT_TAB: begin
            ovf_in = 1'b0;
            rd_in  = 1'b0;
            if (tab_sum > (CURSOR_W + 1)'(CELL_COUNT)) begin
               cursor_in = CURSOR_W'(CELL_COUNT);
            end else begin
               cursor_in = tab_sum[CURSOR_W-1:0];
            end
         end
         ACT_NEWLINE: begin
            ovf_in    = 1'b0;
            rd_in     = 1'b0;
            cursor_in = CURSOR_W'(COLUMNS * int'(line_ff));
            line_in   = line_ff + LINE_W'(1);
         end
         ACT_READ: begin
            ovf_in = 1'b0;
            rd_in  = req_data.cell_address < ADDR_W'(CELL_COUNT);
            mem_re = rd_in;
            mem_ra = CELL_AW'(req_data.cell_address);
         end
         ACT_NOP: begin
            ovf_in = 1'b0;
            rd_in  = 1'b0;
         end
         ACT_CLEAR_START: begin
            ovf_in    = 1'b0;
            rd_in     = 1'b0;
            cursor_in = '0;
            line_in   = LINE_W'(1);
            cnt_in    = '0;
         end
         ACT_SCROLL_START: begin
            ovf_in    = 1'b0;
            rd_in     = 1'b0;
            cursor_in = CURSOR_W'(SCROLL_POS);
            cnt_in    = '0;
         end
         ACT_FILL: begin
            mem_we = 1'b1;
            mem_wa = CELL_AW'(cnt_ff);
            mem_wd = cmd.fill_reset ? BLANK_RESET : blank;
            cnt_in = cnt_ff + CNT_W'(1);
         end
         ACT_SCROLL: begin
            // read one row ahead, write the cell fetched on the previous step
            mem_re = cnt_ff < CNT_W'(COPY_CELLS);
            mem_ra = CELL_AW'(cnt_ff + CNT_W'(COLUMNS));
            mem_we = cnt_ff != '0;
            mem_wa = CELL_AW'(cnt_ff - CNT_W'(1));
            mem_wd = (cnt_ff <= CNT_W'(COPY_CELLS)) ? q_ff : blank;
            if (cnt_ff != CNT_W'(CELL_COUNT)) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ACT_NONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         q_ff <= mem[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         line_ff   <= LINE_W'(1);
         cnt_ff    <= '0;
         ovf_ff    <= 1'b0;
         rd_ff     <= 1'b0;
         fore_ff   <= FORE_RESET;
         back_ff   <= BACK_RESET;
      end else begin
         cursor_ff <= cursor_in;
         line_ff   <= line_in;
         cnt_ff    <= cnt_in;
         ovf_ff    <= ovf_in;
         rd_ff     <= rd_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_FORE_COLOR: fore_ff <= csr_write_data;
               CSR_BACK_COLOR: back_ff <= csr_write_data;
               default: begin
               end
            endcase
         end
      end
   end

   assign sts.fill_last    = cnt_ff == CNT_W'(CELL_COUNT - 1);
   assign sts.scroll_last  = cnt_ff == CNT_W'(CELL_COUNT);
   assign sts.at_last_line = line_ff >= LINE_W'(ROWS);

   assign rsp_data.cell_data   = rd_ff ? q_ff : '0;
   assign rsp_data.cursor_pos  = cursor_ff;
   assign rsp_data.line_number = line_ff;
   assign rsp_data.overflow    = ovf_ff;

   `TCW_ASSERT_IMP(a_no_port_clash, clock, reset, mem_we && mem_re, mem_wa != mem_ra)
   `TCW_ASSERT_NEXT(a_scroll_cursor, clock, reset, cmd.act == ACT_SCROLL_START,
                    cursor_ff == CURSOR_W'(SCROLL_POS))
   `TCW_ASSERT_NEXT(a_clear_home, clock, reset, cmd.act == ACT_CLEAR_START,
                    cursor_ff == '0 && line_ff == LINE_W'(1))

endmodule

>>> hdl/tcw_controller.sv
// Operation sequencer: handshakes, decode and sweep control
`include "text_console_writer_core_defines.svh"

module tcw_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  tcw_pkg::tcw_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  tcw_pkg::tcw_sts_type sts,
   output tcw_pkg::tcw_cmd_type cmd
);
   import tcw_pkg::*;

   typedef enum logic [1:0] {
      S_INIT,
      S_IDLE,
      S_FILL,
      S_SCROLL
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_set;
   logic      req_accept;

   assign req_stall  = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;

   always_comb begin
      state_in       = state_ff;
      rsp_set        = 1'b0;
      cmd.act        = ACT_NONE;
      cmd.fill_reset = 1'b0;
      unique case (state_ff)
         S_INIT: begin
            cmd.act        = ACT_FILL;
            cmd.fill_reset = 1'b1;
            if (sts.fill_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               unique case (req_data.op)
                  OP_PUT: begin
                     if (req_data.char_code == CH_NEWLINE) begin
                        if (sts.at_last_line) begin
                           cmd.act  = ACT_SCROLL_START;
                           state_in = S_SCROLL;
                        end else begin
                           cmd.act = ACT_NEWLINE;
                           rsp_set = 1'b1;
                        end
                     end else if (req_data.char_code == CH_TAB) begin
                        cmd.act = ACT_TAB;
                        rsp_set = 1'b1;
                     end else begin
                        cmd.act = ACT_PUT;
                        rsp_set = 1'b1;
                     end
                  end
                  OP_READ: begin
                     cmd.act = ACT_READ;
                     rsp_set = 1'b1;
                  end
                  OP_CLEAR: begin
                     cmd.act  = ACT_CLEAR_START;
                     state_in = S_FILL;
                  end
                  default: begin
                     cmd.act = ACT_NOP;
                     rsp_set = 1'b1;
                  end
               endcase
            end
         end
         S_FILL: begin
            cmd.act = ACT_FILL;
            if (sts.fill_last) begin
               state_in = S_IDLE;
               rsp_set  = 1'b1;
            end
         end
         S_SCROLL: begin
            cmd.act = ACT_SCROLL;
            if (sts.scroll_last) begin
               state_in = S_IDLE;
               rsp_set  = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_set) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         // drop once the beat is taken
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `TCW_ASSERT_IMP(a_busy_no_rsp, clock, reset, state_ff != S_IDLE, !rsp_valid_ff)
   `TCW_ASSERT_NEXT(a_clear_to_fill, clock, reset,
                    req_accept && req_data.op == OP_CLEAR, state_ff == S_FILL)
   `TCW_ASSERT_NEXT(a_scroll_done, clock, reset,
                    state_ff == S_SCROLL && sts.scroll_last,
                    rsp_valid_ff && state_ff == S_IDLE)

endmodule

>>> hdl/text_console_writer_core.sv
// Text console writer top level: sequencer and cell-store datapath
//
//  Channel  Direction  Handshake            Payload
//  req      in         req_valid/req_stall  tcw_req_type: op, char_code, cell_address
//  rsp      out        rsp_valid/rsp_stall  tcw_rsp_type: cell_data, cursor_pos,
//                                           line_number, overflow
//  csr      in         csr_write_enable     csr_index, csr_write_data
//
// Put character, tab, plain newline, read and the unused op need no sweep; the
// result is registered at the accepting edge (a read through the registered RAM port).
// Clear and a newline on the last line both sweep the cell store one cell per cycle.
// After reset the store is blanked while req_stall stays high.
// A new beat is taken only when the result register is empty or being emptied.

module text_console_writer_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  tcw_pkg::tcw_req_type          req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output tcw_pkg::tcw_rsp_type          rsp_data,
   input  logic                          csr_write_enable,
   input  logic [tcw_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tcw_pkg::COLOR_W-1:0]   csr_write_data
);
   import tcw_pkg::*;

   tcw_cmd_type cmd;
   tcw_sts_type sts;

   tcw_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   tcw_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .sts              (sts),
      .rsp_data         (rsp_data)
   );

endmodule
